### src/irpd_pkg.sv
// irpd_pkg: shared types, constants and helpers for the ir pulse distance decoder
// no dependencies; imported by every module of the block

package irpd_pkg;

    // fixed header windows, exclusive bounds, microseconds
    localparam logic [15:0] HDR_MARK_LO  = 16'd5900;
    localparam logic [15:0] HDR_MARK_HI  = 16'd6300;
    localparam logic [15:0] HDR_SPACE_LO = 16'd7400;
    localparam logic [15:0] HDR_SPACE_HI = 16'd7800;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MARK_MIN       = 3'd0;
    localparam logic [2:0] REG_MARK_MAX       = 3'd1;
    localparam logic [2:0] REG_ZERO_SPACE_MIN = 3'd2;
    localparam logic [2:0] REG_ZERO_SPACE_MAX = 3'd3;
    localparam logic [2:0] REG_ONE_SPACE_MIN  = 3'd4;
    localparam logic [2:0] REG_ONE_SPACE_MAX  = 3'd5;

    // frame status codes
    localparam logic [1:0] ST_BAD_HEADER = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_BAD_SPACE  = 2'd2;
    localparam logic [1:0] ST_RAN_OUT    = 2'd3;

    typedef struct packed {
        logic [15:0] mark_min;
        logic [15:0] mark_max;
        logic [15:0] zero_space_min;
        logic [15:0] zero_space_max;
        logic [15:0] one_space_min;
        logic [15:0] one_space_max;
    } windows_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [6:0]  bits_decoded;
        logic [63:0] code_word;
    } result_t;

    // strict window test
    function automatic logic in_window(
        input logic [15:0] v,
        input logic [15:0] lo,
        input logic [15:0] hi
    );
        return (v > lo) && (v < hi);
    endfunction

endpackage

### src/irpd_cfg_regs.sv
// irpd_cfg_regs: apb-style register file holding the six data window bounds
// depends on irpd_pkg (windows_t, register indexes)

module irpd_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output irpd_pkg::windows_t  windows
);
    import irpd_pkg::*;

    windows_t   win_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready  = 1'b1;
    assign idx     = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign windows = win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.mark_min       <= 16'd400;
            win_reg.mark_max       <= 16'd700;
            win_reg.zero_space_min <= 16'd1300;
            win_reg.zero_space_max <= 16'd1700;
            win_reg.one_space_min  <= 16'd3300;
            win_reg.one_space_max  <= 16'd3700;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MARK_MIN:       win_reg.mark_min       <= pwdata[15:0];
                REG_MARK_MAX:       win_reg.mark_max       <= pwdata[15:0];
                REG_ZERO_SPACE_MIN: win_reg.zero_space_min <= pwdata[15:0];
                REG_ZERO_SPACE_MAX: win_reg.zero_space_max <= pwdata[15:0];
                REG_ONE_SPACE_MIN:  win_reg.one_space_min  <= pwdata[15:0];
                REG_ONE_SPACE_MAX:  win_reg.one_space_max  <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MARK_MIN:       prdata = {16'd0, win_reg.mark_min};
            REG_MARK_MAX:       prdata = {16'd0, win_reg.mark_max};
            REG_ZERO_SPACE_MIN: prdata = {16'd0, win_reg.zero_space_min};
            REG_ZERO_SPACE_MAX: prdata = {16'd0, win_reg.zero_space_max};
            REG_ONE_SPACE_MIN:  prdata = {16'd0, win_reg.one_space_min};
            REG_ONE_SPACE_MAX:  prdata = {16'd0, win_reg.one_space_max};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

### src/irpd_frame_fsm.sv
// irpd_frame_fsm: frame state machine, bit counter and kept code register
// depends on irpd_pkg (windows_t, result_t, status codes, in_window)

module irpd_frame_fsm #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [15:0]         pulse_us,
    input  logic                last_pulse,
    input  irpd_pkg::windows_t  windows,
    output irpd_pkg::result_t   result
);
    import irpd_pkg::*;

    localparam int CODE_W = FRAME_BYTES * 8;
    localparam int IDX_W  = (CODE_W > 1) ? $clog2(CODE_W) : 1;

    typedef enum logic [2:0] {
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_SEEK_MARK,
        PH_SPACE,
        PH_STOPPED
    } phase_t;

    phase_t              phase_reg, phase_next, phase_after;
    logic [6:0]          bit_count_reg, bit_count_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [1:0]          stop_cause_reg, stop_cause_next;
    logic [IDX_W-1:0]    bit_idx;
    logic                zero_hit, one_hit;

    assign bit_idx  = bit_count_reg[IDX_W-1:0];
    assign zero_hit = in_window(pulse_us, windows.zero_space_min, windows.zero_space_max);
    assign one_hit  = in_window(pulse_us, windows.one_space_min, windows.one_space_max);

    // one pulse worth of decoding
    always_comb
    begin
        phase_after     = phase_reg;
        bit_count_next  = bit_count_reg;
        code_next       = code_reg;
        stop_cause_next = stop_cause_reg;
        case (phase_reg)
            PH_HDR_MARK:
            begin
                if (in_window(pulse_us, HDR_MARK_LO, HDR_MARK_HI))
                    phase_after = PH_HDR_SPACE;
                else
                begin
                    phase_after     = PH_STOPPED;
                    stop_cause_next = ST_BAD_HEADER;
                end
            end
            PH_HDR_SPACE:
            begin
                if (in_window(pulse_us, HDR_SPACE_LO, HDR_SPACE_HI))
                    phase_after = PH_SEEK_MARK;
                else
                begin
                    phase_after     = PH_STOPPED;
                    stop_cause_next = ST_BAD_HEADER;
                end
            end
            PH_SEEK_MARK:
            begin
                if (in_window(pulse_us, windows.mark_min, windows.mark_max))
                    phase_after = PH_SPACE;
            end
            PH_SPACE:
            begin
                if (zero_hit || one_hit)
                begin
                    // zero window wins where the two overlap
                    code_next[bit_idx] = !zero_hit;
                    bit_count_next     = bit_count_reg + 7'd1;
                    if (bit_count_next >= 7'(CODE_W))
                    begin
                        phase_after     = PH_STOPPED;
                        stop_cause_next = ST_COMPLETE;
                    end
                    else
                        phase_after = PH_SEEK_MARK;
                end
                else
                begin
                    phase_after     = PH_STOPPED;
                    stop_cause_next = ST_BAD_SPACE;
                end
            end
            default:
                phase_after = PH_STOPPED;
        endcase
        phase_next = phase_after;
    end

    // result of the frame, from the state after this pulse
    always_comb
    begin
        result.code_word    = 64'(code_next);
        result.bits_decoded = bit_count_next;
        if (phase_after == PH_STOPPED)
            result.frame_status = stop_cause_next;
        else if (phase_after == PH_HDR_MARK || phase_after == PH_HDR_SPACE)
            result.frame_status = ST_BAD_HEADER;
        else
            result.frame_status = ST_RAN_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR_MARK;
            bit_count_reg  <= 7'd0;
            code_reg       <= '0;
            stop_cause_reg <= ST_BAD_HEADER;
        end
        else if (step)
        begin
            code_reg <= code_next;
            if (last_pulse)
            begin
                phase_reg      <= PH_HDR_MARK;
                bit_count_reg  <= 7'd0;
                stop_cause_reg <= ST_BAD_HEADER;
            end
            else
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                stop_cause_reg <= stop_cause_next;
            end
        end
    end

endmodule

### src/ir_pulse_distance_decoder.sv
// ir_pulse_distance_decoder: a last pulse beat is held in the input register, then decoded into
// the result register that drives m_tvalid; throughput one beat per
// cycle, set by the combinational window compares and bit write of the frame state machine;
// a last beat waits in the input register only while an unread result holds the result slot
// rst_n is asynchronous and active low: frame state, code register and handshake flags clear,
// window registers return to 400/700, 1300/1700, 3300/3700; uses irpd_pkg, cfg regs and fsm

module ir_pulse_distance_decoder #(
    parameter int FRAME_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] pulse_us
    input  logic        s_tlast,    // last_pulse
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [63:0] code_word, [70:64] bits_decoded,
                                    // [72:71] frame_status, [79:73] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import irpd_pkg::*;

    localparam int CODE_W = FRAME_BYTES * 8;

    windows_t    windows;
    result_t     result;

    // input register
    logic        in_valid_reg;
    logic [15:0] in_pulse_reg;
    logic        in_last_reg;

    // result register
    logic        out_valid_reg;
    result_t     out_data_reg;

    logic        out_free;
    logic        advance;
    logic        step;

    irpd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .windows (windows)
    );

    irpd_frame_fsm #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pulse_us   (in_pulse_reg),
        .last_pulse (in_last_reg),
        .windows    (windows),
        .result     (result)
    );

    // result slot frees when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // only a last beat needs the result slot; other beats always pass
    assign advance  = !in_last_reg || out_free;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (step && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_pulse_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
        if (step && in_last_reg)
            out_data_reg <= result;
    end

    // a held input beat stays until it is decoded
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input beat dropped while result slot busy");

    // bit count never passes the frame size
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.bits_decoded <= 7'(CODE_W))
        else $error("bits_decoded beyond frame size");

    // a complete frame has every bit written
    a_complete_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.frame_status == ST_COMPLETE
        |-> out_data_reg.bits_decoded == 7'(CODE_W))
        else $error("complete status with short bit count");

    // a bad header writes no bits
    a_header_nobits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.frame_status == ST_BAD_HEADER
        |-> out_data_reg.bits_decoded == 7'd0)
        else $error("bad header status with bits written");

endmodule

### dv/ir_pulse_distance_decoder_checker.sv
`timescale 1ns / 100ps
// ir_pulse_distance_decoder_checker: watches the pulse, result and register channels,
// predicts each frame result from its own decoder state and compares it beat by beat
// depends on irpd_pkg

module ir_pulse_distance_decoder_checker #(
    parameter int FRAME_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    import irpd_pkg::*;

    typedef enum logic [2:0] {
        SEEK_HDR_MARK,
        SEEK_HDR_SPACE,
        SEEK_DATA_MARK,
        SEEK_DATA_SPACE,
        STOPPED
    } frame_phase_t;

    localparam windows_t WIN_AT_RESET = windows_t'{16'd400, 16'd700, 16'd1300, 16'd1700,
                                                   16'd3300, 16'd3700};

    windows_t     win;
    frame_phase_t phase;
    logic [6:0]   bit_cnt;
    logic [63:0]  code;
    logic [1:0]   stop_status;
    result_t      frame_results_q[$];
    result_t      want;
    logic [15:0]  shadow;

    initial errors = 0;

    function automatic logic strictly_between(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t ns: %s mismatch, got %h, wanted %h", $realtime, what, got, exp_val);
        errors++;
    endtask

    // one pulse through the frame decoder, queues a result on the last pulse
    task automatic decode_pulse(input logic [15:0] p, input logic last);
        result_t r;
        case (phase)
            SEEK_HDR_MARK:
                if (strictly_between(p, HDR_MARK_LO, HDR_MARK_HI))
                    phase = SEEK_HDR_SPACE;
                else
                begin
                    phase = STOPPED;
                    stop_status = ST_BAD_HEADER;
                end
            SEEK_HDR_SPACE:
                if (strictly_between(p, HDR_SPACE_LO, HDR_SPACE_HI))
                    phase = SEEK_DATA_MARK;
                else
                begin
                    phase = STOPPED;
                    stop_status = ST_BAD_HEADER;
                end
            SEEK_DATA_MARK:
                if (strictly_between(p, win.mark_min, win.mark_max))
                    phase = SEEK_DATA_SPACE;
            SEEK_DATA_SPACE:
            begin
                // zero window wins where the two overlap
                if (strictly_between(p, win.zero_space_min, win.zero_space_max))
                    code[bit_cnt[5:0]] = 1'b0;
                else if (strictly_between(p, win.one_space_min, win.one_space_max))
                    code[bit_cnt[5:0]] = 1'b1;
                else
                begin
                    phase = STOPPED;
                    stop_status = ST_BAD_SPACE;
                end
                if (phase != STOPPED)
                begin
                    bit_cnt = bit_cnt + 7'd1;
                    if (int'(bit_cnt) >= FRAME_BYTES * 8)
                    begin
                        phase = STOPPED;
                        stop_status = ST_COMPLETE;
                    end
                    else
                        phase = SEEK_DATA_MARK;
                end
            end
            default:
                phase = STOPPED;
        endcase

        if (last)
        begin
            r.code_word    = code;
            r.bits_decoded = bit_cnt;
            if (phase == STOPPED)
                r.frame_status = stop_status;
            else if (phase == SEEK_HDR_MARK || phase == SEEK_HDR_SPACE)
                r.frame_status = ST_BAD_HEADER;
            else
                r.frame_status = ST_RAN_OUT;
            frame_results_q.push_back(r);
            phase       = SEEK_HDR_MARK;
            bit_cnt     = '0;
            stop_status = ST_BAD_HEADER;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win         = WIN_AT_RESET;
            phase       = SEEK_HDR_MARK;
            bit_cnt     = '0;
            code        = '0;
            stop_status = ST_BAD_HEADER;
            frame_results_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_results_q.size() == 0)
                    report_mismatch("unexpected result beat", m_tdata[63:0], '0);
                else
                begin
                    want = frame_results_q.pop_front();
                    if (m_tdata[63:0] !== want.code_word)
                        report_mismatch("code_word", m_tdata[63:0], want.code_word);
                    if (m_tdata[70:64] !== want.bits_decoded)
                        report_mismatch("bits_decoded", 64'(m_tdata[70:64]),
                                        64'(want.bits_decoded));
                    if (m_tdata[72:71] !== want.frame_status)
                        report_mismatch("frame_status", 64'(m_tdata[72:71]),
                                        64'(want.frame_status));
                    if (m_tdata[79:73] !== 7'd0)
                        report_mismatch("tdata padding", 64'(m_tdata[79:73]), '0);
                end
            end

            if (s_tvalid && s_tready)
                decode_pulse(s_tdata, s_tlast);

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[4:2])
                        REG_MARK_MIN:       win.mark_min       = pwdata[15:0];
                        REG_MARK_MAX:       win.mark_max       = pwdata[15:0];
                        REG_ZERO_SPACE_MIN: win.zero_space_min = pwdata[15:0];
                        REG_ZERO_SPACE_MAX: win.zero_space_max = pwdata[15:0];
                        REG_ONE_SPACE_MIN:  win.one_space_min  = pwdata[15:0];
                        REG_ONE_SPACE_MAX:  win.one_space_max  = pwdata[15:0];
                        default: ;
                    endcase
                end
                else if (paddr[4:2] <= REG_ONE_SPACE_MAX)
                begin
                    case (paddr[4:2])
                        REG_MARK_MIN:       shadow = win.mark_min;
                        REG_MARK_MAX:       shadow = win.mark_max;
                        REG_ZERO_SPACE_MIN: shadow = win.zero_space_min;
                        REG_ZERO_SPACE_MAX: shadow = win.zero_space_max;
                        REG_ONE_SPACE_MIN:  shadow = win.one_space_min;
                        default:            shadow = win.one_space_max;
                    endcase
                    if (prdata[15:0] !== shadow)
                        report_mismatch("register readback", 64'(prdata[15:0]), 64'(shadow));
                end
            end
        end
        pending = frame_results_q.size();
    end

endmodule

### dv/ir_pulse_distance_decoder_test.sv
`timescale 1ns / 100ps
// ir_pulse_distance_decoder_test: stimulus and verdict for the ir pulse distance decoder
// drives pulse frames, register writes and result back-pressure; checking is done by
// ir_pulse_distance_decoder_checker; depends on irpd_pkg and the decoder rtl

module ir_pulse_distance_decoder_test;
    import irpd_pkg::*;

    // register slots past the last window bound, writes there must be dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // window settings used by the phases of the run
    localparam windows_t WIN_DEFAULT = windows_t'{16'd400, 16'd700, 16'd1300, 16'd1700,
                                                  16'd3300, 16'd3700};
    // widest mark window, zero and one windows overlapping
    localparam windows_t WIN_WIDE    = windows_t'{16'd0, 16'd65535, 16'd0, 16'd2000,
                                                  16'd1500, 16'd65535};
    // single-value mark and one windows, zero window empty (min above max)
    localparam windows_t WIN_NARROW  = windows_t'{16'd500, 16'd502, 16'd65535, 16'd0,
                                                  16'd2999, 16'd3001};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [15:0] pulse_us
    logic        s_tlast;     // last_pulse
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;     // [63:0] code_word, [70:64] bits_decoded,
                              // [72:71] frame_status, [79:73] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;

    // stimulus bookkeeping
    windows_t    cur_win;       // windows as last written, used to shape well-formed frames
    int          pulses_sent;
    bit          steady;        // frame goes out with no gaps between beats
    bit          hold_req;      // asks the result side for one long hold-off

    ir_pulse_distance_decoder #(
        .FRAME_BYTES(8)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ir_pulse_distance_decoder_checker #(
        .FRAME_BYTES(8)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random ready with bursts and short stalls, plus one long
    // hold-off on request so the decoder fills up and stalls the pulse side
    initial
    begin
        int hold_left;
        int run_left;
        int r;
        hold_left = 0;
        run_left  = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                m_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    m_tready <= 1'b1;
                else if (r < 85)
                    m_tready <= 1'b0;
                else if (r < 95)
                begin
                    run_left = $urandom_range(10, 60);
                    m_tready <= 1'b1;
                end
                else
                begin
                    hold_left = $urandom_range(5, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // gap before a pulse beat: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // a duration strictly inside (lo, hi); any value when the window is empty
    function automatic logic [15:0] pick_inside(logic [15:0] lo, logic [15:0] hi);
        if (int'(hi) > int'(lo) + 1)
            return 16'($urandom_range(int'(lo) + 1, int'(hi) - 1));
        return 16'($urandom);
    endfunction

    // a duration outside (lo, hi), the bounds themselves often
    function automatic logic [15:0] pick_outside(logic [15:0] lo, logic [15:0] hi);
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default:
            begin
                v = 16'($urandom);
                if (v > lo && v < hi)
                    return hi;
                return v;
            end
        endcase
    endfunction

    // one pulse beat, optional gap first, held until accepted
    task automatic send_pulse(input logic [15:0] p, input logic last);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        pulses_sent++;
    endtask

    // a run of pulses, the final one flagged as last when asked
    task automatic send_pulses(input logic [15:0] q[$], input bit with_last);
        foreach (q[i])
            send_pulse(q[i], with_last && (i == q.size() - 1));
    endtask

    // pulse side quiet, every result back, pipeline drained
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic reg_access(input logic [2:0] idx, input bit wr, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};   // upper half is noise the register drops
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // all six bounds written, spare slots poked, then read back for the checker
    task automatic set_windows(input windows_t w);
        cur_win = w;
        reg_access(REG_MARK_MIN,       1'b1, w.mark_min);
        reg_access(REG_MARK_MAX,       1'b1, w.mark_max);
        reg_access(REG_ZERO_SPACE_MIN, 1'b1, w.zero_space_min);
        reg_access(REG_ZERO_SPACE_MAX, 1'b1, w.zero_space_max);
        reg_access(REG_ONE_SPACE_MIN,  1'b1, w.one_space_min);
        reg_access(REG_ONE_SPACE_MAX,  1'b1, w.one_space_max);
        reg_access(REG_SPARE_A,        1'b1, 16'($urandom));
        reg_access(REG_SPARE_B,        1'b1, 16'($urandom));
        for (int i = 0; i <= int'(REG_ONE_SPACE_MAX); i++)
            reg_access(3'(i), 1'b0, '0);
    endtask

    function automatic windows_t random_windows();
        windows_t w;
        w.mark_min       = 16'($urandom_range(0, 60000));
        w.mark_max       = w.mark_min + 16'($urandom_range(2, 4000));
        w.zero_space_min = 16'($urandom_range(0, 60000));
        w.zero_space_max = w.zero_space_min + 16'($urandom_range(2, 4000));
        w.one_space_min  = 16'($urandom_range(0, 60000));
        w.one_space_max  = w.one_space_min + 16'($urandom_range(2, 4000));
        return w;
    endfunction

    // mostly well-formed frames under the current windows, with noise between
    // marks, broken headers, bad spaces, full 64-bit frames and truncated tails
    task automatic random_frame();
        logic [15:0] q[$];
        int          nbits;
        int          r;
        steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 88)
        begin
            q.push_back(pick_inside(HDR_MARK_LO, HDR_MARK_HI));
            q.push_back(pick_inside(HDR_SPACE_LO, HDR_SPACE_HI));
        end
        else if (r < 94)
        begin
            q.push_back(pick_outside(HDR_MARK_LO, HDR_MARK_HI));
            q.push_back(16'($urandom));
        end
        else
        begin
            q.push_back(pick_inside(HDR_MARK_LO, HDR_MARK_HI));
            q.push_back(pick_outside(HDR_SPACE_LO, HDR_SPACE_HI));
        end

        // a few frames reach or run past 64 bits to hit the completion stop
        nbits = ($urandom_range(0, 99) < 8) ? 64 + $urandom_range(0, 3) : $urandom_range(0, 10);
        repeat (nbits)
        begin
            if ($urandom_range(0, 99) < 15)
                q.push_back(pick_outside(cur_win.mark_min, cur_win.mark_max));
            q.push_back(pick_inside(cur_win.mark_min, cur_win.mark_max));
            r = $urandom_range(0, 99);
            if (r < 3)
                q.push_back(16'($urandom));
            else if (r < 50)
                q.push_back(pick_inside(cur_win.zero_space_min, cur_win.zero_space_max));
            else
                q.push_back(pick_inside(cur_win.one_space_min, cur_win.one_space_max));
        end

        r = $urandom_range(0, 99);
        if (r >= 40 && r < 70)
            q.push_back(pick_inside(cur_win.mark_min, cur_win.mark_max));   // ends on a mark
        else if (r >= 70 && r < 85)
            repeat ($urandom_range(0, q.size() - 1)) void'(q.pop_back());   // cut short
        else if (r >= 85)
            repeat ($urandom_range(1, 3)) q.push_back(16'($urandom));
        send_pulses(q, 1'b1);
    endtask

    task automatic random_phase(input int count);
        int target;
        target = pulses_sent + count;
        while (pulses_sent < target)
            random_frame();
        wait_idle();
    endtask

    // stimulus
    initial
    begin
        logic [15:0] q[$];

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        hold_req    = 1'b0;
        steady      = 1'b0;
        pulses_sent = 0;
        cur_win     = WIN_DEFAULT;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames under the reset windows
        steady = 1'b1;
        // field extremes: bad header mark, rest ignored
        q = '{16'd0, 16'd65535};
        send_pulses(q, 1'b1);
        // frame ends after the header mark
        q = '{16'd6000};
        send_pulses(q, 1'b1);
        // zero bit, skipped noise, one attempt with a bad space, pulse after the stop
        q = '{16'd6100, 16'd7600, 16'd550, 16'd1500, 16'd100, 16'd550, 16'd2500, 16'd65535};
        send_pulses(q, 1'b1);
        // just-inside bounds everywhere, frame ends on a mark
        q = '{16'd6299, 16'd7401, 16'd401, 16'd1699, 16'd699};
        send_pulses(q, 1'b1);
        wait_idle();
        // read back the reset values
        for (int i = 0; i <= int'(REG_ONE_SPACE_MAX); i++)
            reg_access(3'(i), 1'b0, '0);

        random_phase(280);

        // long result hold-off with short frames pushed back to back
        hold_req = 1'b1;
        steady   = 1'b1;
        repeat (40)
        begin
            q.delete();
            q.push_back(16'($urandom));
            if ($urandom_range(0, 1))
                q.push_back(16'($urandom));
            send_pulses(q, 1'b1);
        end
        wait_idle();

        // windows change in the middle of a frame, new bounds apply to the rest
        q = '{16'd6100, 16'd7600, 16'd550, 16'd1500, 16'd550, 16'd3500};
        send_pulses(q, 1'b0);
        wait_idle();
        set_windows(WIN_WIDE);
        // 1800 sits in both data windows, zero must win; 65535 is outside the one window
        q = '{16'd30000, 16'd1800, 16'd100, 16'd40000, 16'd200, 16'd65535};
        send_pulses(q, 1'b1);
        wait_idle();

        random_phase(280);

        set_windows(WIN_NARROW);
        random_phase(250);

        repeat (3)
        begin
            set_windows(random_windows());
            random_phase(220);
        end

        // back to the reset windows for the final stretch
        set_windows(WIN_DEFAULT);
        random_phase(80);

        @(negedge clk);
        wait (pending == 0);
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
